FILE: src/rotary_encoder_detent_decoder_macros.svh
// Assertion macros for the rotary encoder detent decoder checker.
// Expects signals named clk and rst_n in the scope of use.
`ifndef ROTARY_ENCODER_DETENT_DECODER_MACROS_SVH
`define ROTARY_ENCODER_DETENT_DECODER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RED_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RED_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/red_pkg.sv
// Shared types and constants for the rotary encoder detent decoder.
// No dependencies.
package red_pkg;

  localparam int TIME_WIDTH_DEF = 32;

  localparam int GAP_W   = 16;
  localparam int COUNT_W = 4;
  localparam int CFG_IDX_W = 2;
  localparam int RESULT_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_EDGE_GAP_US     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BUTTON_GAP_MS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_TRANSITIONS = 2'd2;

  localparam logic [GAP_W-1:0]   EDGE_GAP_US_RST     = 16'd1000;
  localparam logic [GAP_W-1:0]   BUTTON_GAP_MS_RST   = 16'd250;
  localparam logic [COUNT_W-1:0] MIN_TRANSITIONS_RST = 4'd4;
  localparam logic [COUNT_W-1:0] COUNT_MAX           = 4'd15;

  localparam logic [1:0] PINS_DETENT   = 2'b11;
  localparam logic [1:0] PINS_DT_ONLY  = 2'b10;
  localparam logic [1:0] PINS_CLK_ONLY = 2'b01;

  localparam logic [1:0] DIR_NONE = 2'b00;
  localparam logic [1:0] DIR_POS  = 2'b01;
  localparam logic [1:0] DIR_NEG  = 2'b11;

  typedef struct packed {
    logic [COUNT_W-1:0] min_transitions;
    logic [GAP_W-1:0]   button_gap_ms;
    logic [GAP_W-1:0]   edge_gap_us;
  } cfg_t;

  typedef struct packed {
    logic [RESULT_W-5:0] pad;
    logic                rotation_pending;
    logic                button_pressed;
    logic signed [1:0]   rotation;
  } result_t;

endpackage

FILE: src/red_cfg.sv
// Configuration register file for the rotary encoder detent decoder.
// Depends on red_pkg.
module red_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [red_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [red_pkg::GAP_W-1:0]    cfg_data,
  output red_pkg::cfg_t                cfg
);

  red_pkg::cfg_t cfg_r;
  red_pkg::cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        red_pkg::CFG_EDGE_GAP_US:     cfg_nxt.edge_gap_us = cfg_data;
        red_pkg::CFG_BUTTON_GAP_MS:   cfg_nxt.button_gap_ms = cfg_data;
        red_pkg::CFG_MIN_TRANSITIONS:
          cfg_nxt.min_transitions = cfg_data[red_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.edge_gap_us     <= red_pkg::EDGE_GAP_US_RST;
      cfg_r.button_gap_ms   <= red_pkg::BUTTON_GAP_MS_RST;
      cfg_r.min_transitions <= red_pkg::MIN_TRANSITIONS_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

FILE: src/red_stage_reg.sv
// One pipeline register stage with valid/ready flow control.
// No dependencies.
module red_stage_reg #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         s_valid,
  output logic         s_ready,
  input  logic [W-1:0] s_data,
  output logic         m_valid,
  input  logic         m_ready,
  output logic [W-1:0] m_data
);

  logic         valid_r;
  logic [W-1:0] data_r;

  assign s_ready = !valid_r || m_ready;
  assign m_valid = valid_r;
  assign m_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (s_ready) begin
      valid_r <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_ready && s_valid) begin
      data_r <= s_data;
    end
  end

endmodule

FILE: src/red_core.sv
// Decoder state and per-transaction update: edge gates, detent logic, takes.
// Depends on red_pkg.
module red_core #(
  parameter int TIME_WIDTH = red_pkg::TIME_WIDTH_DEF,
  parameter int IN_W       = 72
) (
  input  logic              clk,
  input  logic              rst_n,
  input  red_pkg::cfg_t     cfg,
  input  logic              fire,
  input  logic [IN_W-1:0]   item,
  output red_pkg::result_t  result
);

  localparam int US_LSB = 4;
  localparam int MS_LSB = US_LSB + TIME_WIDTH;
  localparam int TK_LSB = MS_LSB + TIME_WIDTH;

  logic [1:0]                  pins;
  logic                        enc_edge;
  logic                        btn_edge;
  logic [TIME_WIDTH-1:0]       now_us;
  logic [TIME_WIDTH-1:0]       now_ms;
  logic                        take_rot;
  logic                        take_btn;

  logic [1:0]                  last_pins_r, last_pins_nxt;
  logic [red_pkg::COUNT_W-1:0] count_r, count_nxt, count_inc;
  logic [1:0]                  dir_r, dir_nxt;
  logic                        rot_flag_r, rot_flag_nxt, rot_flag_mid;
  logic                        press_r, press_nxt, press_mid;
  logic [TIME_WIDTH-1:0]       last_enc_r, last_enc_nxt;
  logic [TIME_WIDTH-1:0]       last_btn_r, last_btn_nxt;
  logic [TIME_WIDTH-1:0]       last_press_r, last_press_nxt;
  logic [TIME_WIDTH-1:0]       edge_gap, button_gap;
  logic                        enc_ok, btn_ok, lockout_ok;

  assign pins     = {item[0], item[1]};
  assign enc_edge = item[2];
  assign btn_edge = item[3];
  assign now_us   = item[US_LSB +: TIME_WIDTH];
  assign now_ms   = item[MS_LSB +: TIME_WIDTH];
  assign take_rot = item[TK_LSB];
  assign take_btn = item[TK_LSB + 1];

  assign edge_gap   = {{(TIME_WIDTH - red_pkg::GAP_W){1'b0}}, cfg.edge_gap_us};
  assign button_gap = {{(TIME_WIDTH - red_pkg::GAP_W){1'b0}}, cfg.button_gap_ms};

  assign enc_ok     = enc_edge && ((now_us - last_enc_r) > edge_gap);
  assign btn_ok     = btn_edge && ((now_us - last_btn_r) > edge_gap);
  assign lockout_ok = (now_ms - last_press_r) > button_gap;
  assign count_inc  = (count_r == red_pkg::COUNT_MAX) ? count_r : count_r + 1'b1;

  always_comb begin
    last_pins_nxt  = last_pins_r;
    count_nxt      = count_r;
    dir_nxt        = dir_r;
    rot_flag_mid   = rot_flag_r;
    press_mid      = press_r;
    last_enc_nxt   = last_enc_r;
    last_btn_nxt   = last_btn_r;
    last_press_nxt = last_press_r;

    if (enc_ok) begin
      if (pins != last_pins_r) begin
        count_nxt = count_inc;
        if (pins == red_pkg::PINS_DETENT) begin
          if (count_inc >= cfg.min_transitions) begin
            if (last_pins_r == red_pkg::PINS_DT_ONLY) begin
              dir_nxt = red_pkg::DIR_NEG;
            end else if (last_pins_r == red_pkg::PINS_CLK_ONLY) begin
              dir_nxt = red_pkg::DIR_POS;
            end
            rot_flag_mid = 1'b1;
          end
          count_nxt = '0;
        end
      end
      last_pins_nxt = pins;
      last_enc_nxt  = now_us;
    end

    if (btn_ok) begin
      if (lockout_ok) begin
        press_mid      = 1'b1;
        last_press_nxt = now_ms;
      end
      last_btn_nxt = now_us;
    end

    rot_flag_nxt = rot_flag_mid && !take_rot;
    press_nxt    = press_mid && !take_btn;

    result                  = '0;
    result.rotation         = (take_rot && rot_flag_mid) ? dir_nxt : red_pkg::DIR_NONE;
    result.button_pressed   = take_btn && press_mid;
    result.rotation_pending = rot_flag_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_pins_r  <= red_pkg::PINS_DETENT;
      count_r      <= '0;
      dir_r        <= red_pkg::DIR_NONE;
      rot_flag_r   <= 1'b0;
      press_r      <= 1'b0;
      last_enc_r   <= '0;
      last_btn_r   <= '0;
      last_press_r <= '0;
    end else if (fire) begin
      last_pins_r  <= last_pins_nxt;
      count_r      <= count_nxt;
      dir_r        <= dir_nxt;
      rot_flag_r   <= rot_flag_nxt;
      press_r      <= press_nxt;
      last_enc_r   <= last_enc_nxt;
      last_btn_r   <= last_btn_nxt;
      last_press_r <= last_press_nxt;
    end
  end

endmodule

FILE: src/rotary_encoder_detent_decoder.sv
// Top level of the rotary encoder detent decoder: input register, update core,
// result register and configuration registers. Depends on red_pkg and submodules.
//
//  Channel  Direction  Payload
//  in_      slave      tdata: encoder pins, edge events, timestamps, take requests
//  out_     master     tdata: rotation, button_pressed, rotation_pending
//  cfg_     slave      cfg_index, cfg_data (always ready)
//
// Every input transaction yields exactly one result transaction.
// A result passes through the input register and then the result register before it is valid.
// A new transaction is accepted every cycle while the result side keeps up.
// Reset is synchronous and clears the decoder state and all valid flags.
// A stall on out_tready backs up through both register stages to in_tready.
module rotary_encoder_detent_decoder #(
  parameter int TIME_WIDTH = red_pkg::TIME_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Fields from bit 0: dt_level, clk_level, encoder_edge, button_edge,
  // now_us, now_ms, take_rotation, take_button, zero fill.
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [((2*TIME_WIDTH+6+7)/8)*8-1:0] in_tdata,
  // Fields from bit 0: rotation[1:0], button_pressed, rotation_pending, zero fill.
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [red_pkg::RESULT_W-1:0]      out_tdata,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [red_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [red_pkg::GAP_W-1:0]         cfg_data
);

  localparam int IN_W = ((2 * TIME_WIDTH + 6 + 7) / 8) * 8;

  red_pkg::cfg_t    cfg;
  red_pkg::result_t result;
  logic             s1_valid;
  logic             s1_ready;
  logic [IN_W-1:0]  s1_data;
  logic             fire;

  assign fire = s1_valid && s1_ready;

  red_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  red_stage_reg #(.W(IN_W)) u_in_reg (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_valid (in_tvalid),
    .s_ready (in_tready),
    .s_data  (in_tdata),
    .m_valid (s1_valid),
    .m_ready (s1_ready),
    .m_data  (s1_data)
  );

  red_core #(.TIME_WIDTH(TIME_WIDTH), .IN_W(IN_W)) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .fire   (fire),
    .item   (s1_data),
    .result (result)
  );

  red_stage_reg #(.W(red_pkg::RESULT_W)) u_out_reg (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_valid (s1_valid),
    .s_ready (s1_ready),
    .s_data  (result),
    .m_valid (out_tvalid),
    .m_ready (out_tready),
    .m_data  (out_tdata)
  );

endmodule

FILE: src/red_checker.sv
// Port-level checks for the rotary encoder detent decoder, bound to the top.
// Depends on rotary_encoder_detent_decoder_macros.svh.
`include "rotary_encoder_detent_decoder_macros.svh"

module red_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [3:0] out_tdata
);

  `RED_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "stalled result changed")
  `RED_ASSERT_NOW(a_rot_code, out_tvalid, out_tdata[1:0] != 2'b10, "illegal rotation code")
  `RED_ASSERT_NOW(a_rot_clears, out_tvalid && out_tdata[1:0] != 2'b00, !out_tdata[3], "taken rotation still pending")
  `RED_ASSERT_NOW(a_ready_idle, !out_tvalid, in_tready, "input stalled with empty result stage")

endmodule

bind rotary_encoder_detent_decoder red_checker u_red_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata[3:0])
);

FILE: bench/rotary_encoder_detent_decoder_checker.sv
`timescale 1ns / 1ps
// Checker for the rotary encoder detent decoder: watches the in_, out_ and cfg_ channels,
// predicts each result from its own copy of the decoder state and compares field by field.
// Depends on red_pkg for the result layout, register indexes and reset values.
module rotary_encoder_detent_decoder_checker #(
  parameter int TIME_WIDTH = red_pkg::TIME_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  input  logic                                in_tready,
  input  logic [((2*TIME_WIDTH+6+7)/8)*8-1:0] in_tdata,
  input  logic                                out_tvalid,
  input  logic                                out_tready,
  input  logic [red_pkg::RESULT_W-1:0]        out_tdata,
  input  logic                                cfg_valid,
  input  logic                                cfg_ready,
  input  logic [red_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [red_pkg::GAP_W-1:0]           cfg_data,
  output int                                  fail_count,
  output int                                  backlog
);
  import red_pkg::*;

  localparam int IN_W = ((2*TIME_WIDTH+6+7)/8)*8;

  cfg_t                  settings;
  logic [1:0]            pins_seen;
  logic [COUNT_W-1:0]    changes;
  logic [1:0]            heading;
  logic                  rot_flag;
  logic                  press_held;
  logic [TIME_WIDTH-1:0] enc_stamp_us;
  logic [TIME_WIDTH-1:0] btn_stamp_us;
  logic [TIME_WIDTH-1:0] press_stamp_ms;
  result_t               due_results[$];

  function automatic logic gap_elapsed(input logic [TIME_WIDTH-1:0] now, since,
                                       input logic [GAP_W-1:0] gap);
    logic [TIME_WIDTH-1:0] span;
    span = now - since;
    return span > gap;
  endfunction

  function automatic result_t decode_sample(input logic [IN_W-1:0] word);
    logic [1:0]            pins;
    logic                  enc_edge;
    logic                  btn_edge;
    logic                  take_rot;
    logic                  take_btn;
    logic [TIME_WIDTH-1:0] us;
    logic [TIME_WIDTH-1:0] ms;
    result_t               res;
    pins     = {word[0], word[1]};
    enc_edge = word[2];
    btn_edge = word[3];
    us       = word[4 +: TIME_WIDTH];
    ms       = word[4+TIME_WIDTH +: TIME_WIDTH];
    take_rot = word[4+2*TIME_WIDTH];
    take_btn = word[5+2*TIME_WIDTH];
    res = '0;
    if (enc_edge && gap_elapsed(us, enc_stamp_us, settings.edge_gap_us)) begin
      if (pins != pins_seen) begin
        if (changes != COUNT_MAX) begin
          changes = changes + 1'b1;
        end
        if (pins == PINS_DETENT) begin
          if (changes >= settings.min_transitions) begin
            if (pins_seen == PINS_DT_ONLY) begin
              heading = DIR_NEG;
            end else if (pins_seen == PINS_CLK_ONLY) begin
              heading = DIR_POS;
            end
            rot_flag = 1'b1;
          end
          changes = '0;
        end
      end
      pins_seen    = pins;
      enc_stamp_us = us;
    end
    if (btn_edge && gap_elapsed(us, btn_stamp_us, settings.edge_gap_us)) begin
      if (gap_elapsed(ms, press_stamp_ms, settings.button_gap_ms)) begin
        press_held     = 1'b1;
        press_stamp_ms = ms;
      end
      btn_stamp_us = us;
    end
    if (take_rot && rot_flag) begin
      rot_flag     = 1'b0;
      res.rotation = heading;
    end
    if (take_btn && press_held) begin
      press_held         = 1'b0;
      res.button_pressed = 1'b1;
    end
    res.rotation_pending = rot_flag;
    return res;
  endfunction

  always @(posedge clk) begin : watch
    result_t seen;
    result_t want;
    int      bad;
    bad = 0;
    if (!rst_n) begin
      settings.edge_gap_us     = EDGE_GAP_US_RST;
      settings.button_gap_ms   = BUTTON_GAP_MS_RST;
      settings.min_transitions = MIN_TRANSITIONS_RST;
      pins_seen      = PINS_DETENT;
      changes        = '0;
      heading        = DIR_NONE;
      rot_flag       = 1'b0;
      press_held     = 1'b0;
      enc_stamp_us   = '0;
      btn_stamp_us   = '0;
      press_stamp_ms = '0;
      due_results.delete();
      fail_count <= 0;
      backlog    <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_EDGE_GAP_US:     settings.edge_gap_us = cfg_data;
          CFG_BUTTON_GAP_MS:   settings.button_gap_ms = cfg_data;
          CFG_MIN_TRANSITIONS: settings.min_transitions = cfg_data[COUNT_W-1:0];
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        seen = out_tdata;
        if (due_results.size() == 0) begin
          $display("%0t: unexpected result transaction %h", $time, out_tdata);
          bad = 1;
        end else begin
          want = due_results.pop_front();
          if (seen.rotation !== want.rotation) begin
            $display("%0t: rotation expected %0d, actual %0d", $time, want.rotation,
                     seen.rotation);
            bad = 1;
          end
          if (seen.button_pressed !== want.button_pressed) begin
            $display("%0t: button_pressed expected %0d, actual %0d", $time,
                     want.button_pressed, seen.button_pressed);
            bad = 1;
          end
          if (seen.rotation_pending !== want.rotation_pending) begin
            $display("%0t: rotation_pending expected %0d, actual %0d", $time,
                     want.rotation_pending, seen.rotation_pending);
            bad = 1;
          end
          if (seen.pad !== want.pad) begin
            $display("%0t: zero fill expected %h, actual %h", $time, want.pad, seen.pad);
            bad = 1;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        due_results.push_back(decode_sample(in_tdata));
      end
      fail_count <= fail_count + bad;
      backlog    <= due_results.size();
    end
  end

endmodule

FILE: bench/rotary_encoder_detent_decoder_test.sv
`timescale 1ns / 1ps
// Top of the rotary encoder detent decoder bench: clock, reset, register writes, encoder
// and button stimulus and flow control; the checker module does all result checking.
// Depends on red_pkg, rotary_encoder_detent_decoder and rotary_encoder_detent_decoder_checker.
module rotary_encoder_detent_decoder_test;
  import red_pkg::*;

  localparam int TW   = TIME_WIDTH_DEF;
  localparam int IN_W = ((2*TW+6+7)/8)*8;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam int HOLD_CYCLES = 64;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  // Fields from bit 0: dt_level, clk_level, encoder_edge, button_edge, now_us, now_ms,
  // take_rotation, take_button, zero fill.
  logic [IN_W-1:0]      in_tdata = '0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  // Fields from bit 0: rotation[1:0], button_pressed, rotation_pending, zero fill.
  logic [RESULT_W-1:0]  out_tdata;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [GAP_W-1:0]     cfg_data = '0;
  int                   fail_count;
  int                   backlog;

  int                   send_idle_pct = 9;
  int                   recv_idle_pct = 45;
  int                   holds_asked = 0;
  int                   sent = 0;
  logic [TW-1:0]        us_now = '0;
  logic [TW-1:0]        ms_now = '0;
  logic [GAP_W-1:0]     edge_gap = EDGE_GAP_US_RST;
  logic [GAP_W-1:0]     press_gap = BUTTON_GAP_MS_RST;

  rotary_encoder_detent_decoder uut (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .out_tvalid, .out_tready, .out_tdata,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  rotary_encoder_detent_decoder_checker detent_check (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .out_tvalid, .out_tready, .out_tdata,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data, .fail_count, .backlog
  );

  always #5 clk = ~clk;

  function automatic logic chance(input int pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  task automatic offer_item(input logic [1:0] pins, input logic enc, btn,
                            input logic [TW-1:0] us, ms, input logic take_r, take_b);
    logic [IN_W-1:0] word;
    word = '0;
    word[0] = pins[1];
    word[1] = pins[0];
    word[2] = enc;
    word[3] = btn;
    word[4 +: TW] = us;
    word[4+TW +: TW] = ms;
    word[4+2*TW] = take_r;
    word[5+2*TW] = take_b;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= word;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [GAP_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic program_regs(input logic [GAP_W-1:0] gap_us, gap_ms, changes_word);
    write_reg(CFG_EDGE_GAP_US, gap_us);
    write_reg(CFG_BUTTON_GAP_MS, gap_ms);
    write_reg(CFG_MIN_TRANSITIONS, changes_word);
    write_reg(CFG_SPARE, GAP_W'($urandom));
    cfg_valid <= 1'b0;
    edge_gap  = gap_us;
    press_gap = gap_ms;
  endtask

  task automatic settle;
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (backlog != 0) @(posedge clk);
  endtask

  task automatic advance_us(input logic clear);
    if (clear) begin
      us_now += edge_gap + 1 + $urandom_range(0, 400);
    end else begin
      us_now += $urandom_range(0, edge_gap);
    end
  endtask

  task automatic turn_detent(input logic forward);
    logic [7:0] path;
    path = forward ? {PINS_DETENT, PINS_CLK_ONLY, 2'b00, PINS_DT_ONLY}
                   : {PINS_DETENT, PINS_DT_ONLY, 2'b00, PINS_CLK_ONLY};
    for (int k = 0; k < 4; k++) begin
      if (chance(20)) begin
        advance_us(1'b0);
        offer_item(2'($urandom), 1'b1, 1'b0, us_now, ms_now, chance(5), chance(5));
      end
      advance_us(1'b1);
      ms_now += $urandom_range(0, 2);
      offer_item(path[2*k +: 2], 1'b1, chance(8), us_now, ms_now, chance(25), chance(15));
    end
  endtask

  task automatic wobble;
    int n;
    n = $urandom_range(3, 20);
    repeat (n) begin
      advance_us(1'b1);
      offer_item(2'($urandom_range(0, 2)), 1'b1, 1'b0, us_now, ms_now, chance(10), 1'b0);
    end
    advance_us(1'b1);
    offer_item(PINS_DETENT, 1'b1, 1'b0, us_now, ms_now, chance(50), chance(10));
  endtask

  task automatic press_button;
    int pick;
    pick = $urandom_range(0, 3);
    advance_us(chance(85));
    if (pick == 0) begin
      ms_now += press_gap;
    end else if (pick == 1) begin
      ms_now += press_gap + 1;
    end else begin
      ms_now += $urandom_range(0, 2 * press_gap + 2);
    end
    offer_item(2'($urandom), chance(10), 1'b1, us_now, ms_now, chance(20), chance(60));
  endtask

  task automatic run_phase(input int items, input logic with_hold);
    int goal;
    int pick;
    goal = sent + items;
    while (sent < goal) begin
      if (with_hold && holds_asked == 0 && goal - sent < items / 2) begin
        holds_asked++;
      end
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        turn_detent(1'($urandom_range(0, 1)));
      end else if (pick < 55) begin
        wobble();
      end else if (pick < 75) begin
        press_button();
      end else if (pick < 90) begin
        offer_item(2'($urandom), 1'($urandom), 1'($urandom), $urandom, $urandom,
                   1'($urandom), 1'($urandom));
      end else begin
        offer_item(2'($urandom), 1'b0, 1'b0, $urandom, $urandom, chance(70), chance(70));
      end
    end
  endtask

  initial begin : drain
    int holds_done;
    holds_done = 0;
    @(posedge clk);
    forever begin
      if (holds_done != holds_asked) begin
        holds_done++;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Gate boundary, counter-clockwise and clockwise detents, take in the same transaction.
    offer_item(PINS_CLK_ONLY, 1'b1, 1'b0, 1000, 0, 1'b0, 1'b0);
    offer_item(PINS_CLK_ONLY, 1'b1, 1'b0, 1001, 0, 1'b0, 1'b0);
    offer_item(2'b00, 1'b1, 1'b0, 2002, 0, 1'b0, 1'b0);
    offer_item(PINS_DT_ONLY, 1'b1, 1'b0, 3003, 0, 1'b0, 1'b0);
    offer_item(PINS_DETENT, 1'b1, 1'b0, 4004, 0, 1'b1, 1'b0);
    offer_item(PINS_DETENT, 1'b1, 1'b0, 5005, 0, 1'b0, 1'b0);
    offer_item(PINS_DT_ONLY, 1'b1, 1'b0, 6006, 0, 1'b0, 1'b0);
    offer_item(2'b00, 1'b1, 1'b0, 7007, 0, 1'b0, 1'b0);
    offer_item(PINS_CLK_ONLY, 1'b1, 1'b0, 8008, 0, 1'b0, 1'b0);
    offer_item(PINS_DETENT, 1'b1, 1'b0, 9009, 0, 1'b0, 1'b0);
    offer_item(2'b00, 1'b0, 1'b0, 9010, 0, 1'b1, 1'b0);
    offer_item(2'b00, 1'b0, 1'b0, 9011, 0, 1'b1, 1'b0);
    // Too few changes, then a detent reached from the both-low state.
    offer_item(PINS_CLK_ONLY, 1'b1, 1'b0, 10010, 0, 1'b0, 1'b0);
    offer_item(PINS_DETENT, 1'b1, 1'b0, 11011, 0, 1'b0, 1'b0);
    offer_item(PINS_CLK_ONLY, 1'b1, 1'b0, 12012, 0, 1'b0, 1'b0);
    offer_item(2'b00, 1'b1, 1'b0, 13013, 0, 1'b0, 1'b0);
    offer_item(PINS_CLK_ONLY, 1'b1, 1'b0, 14014, 0, 1'b0, 1'b0);
    offer_item(2'b00, 1'b1, 1'b0, 15015, 0, 1'b0, 1'b0);
    offer_item(PINS_DETENT, 1'b1, 1'b0, 16016, 0, 1'b0, 1'b0);
    // Button press, lockout, bounce, then all-ones and a wrapped timestamp.
    offer_item(PINS_DETENT, 1'b1, 1'b1, 17017, 251, 1'b1, 1'b1);
    offer_item(PINS_DETENT, 1'b0, 1'b1, 18018, 501, 1'b0, 1'b1);
    offer_item(PINS_DETENT, 1'b0, 1'b1, 18500, 1000, 1'b0, 1'b1);
    offer_item(PINS_DETENT, 1'b1, 1'b1, '1, '1, 1'b1, 1'b1);
    offer_item(2'b00, 1'b1, 1'b0, 0, 0, 1'b0, 1'b0);
    offer_item(2'b00, 1'b1, 1'b0, 1001, 0, 1'b0, 1'b0);
    us_now = 1001;
    ms_now = 1000;

    run_phase(205, 1'b0);

    settle();
    program_regs(16'd0, 16'd0, 16'd1);
    run_phase(205, 1'b0);

    settle();
    send_idle_pct = 45;
    recv_idle_pct = 9;
    us_now = 32'hFFFF_8000;
    ms_now = 32'hFFFF_F000;
    program_regs(16'hFFFF, 16'hFFFF, 16'd15);
    run_phase(205, 1'b0);

    settle();
    program_regs(16'd37, 16'd3, 16'h00F0);
    run_phase(205, 1'b0);

    settle();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    program_regs(16'd300, 16'd40, 16'd2);
    run_phase(205, 1'b1);

    settle();
    repeat (4) @(posedge clk);
    if (fail_count == 0) begin
      $display("rotary_encoder_detent_decoder_test passed");
    end else begin
      $display("rotary_encoder_detent_decoder_test failed");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("rotary_encoder_detent_decoder_test failed");
    $finish;
  end

endmodule
